// ----- rtl/bfsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsm_pkg
// Shared types, sizes and helpers for the byte FIFO with sync marks.
// ----------------------------------------------------------------------------
package bfsm_pkg;

  localparam int Depth = 64;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int ByteW = 8;
  localparam int OccW  = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_MARK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [ByteW-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [ByteW-1:0] data_out;
    logic             sync_mark;
    logic [OccW-1:0]  occupancy;
    logic             error_status;
  } out_item_t;

  typedef struct packed {
    logic            accepted;
    logic            pop_ok;
    logic            sync_mark;
    logic [OccW-1:0] occupancy;
    logic            error_status;
  } beat_info_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } ram_req_t;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    res = (idx == IdxW'(Depth - 1)) ? '0 : idx + IdxW'(1);
    return res;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    res = (idx == '0) ? IdxW'(Depth - 1) : idx - IdxW'(1);
    return res;
  endfunction

  function automatic logic [OccW-1:0] occ_of(input logic [CntW-1:0] cnt);
    logic [CntW+OccW-1:0] wide;
    wide = (CntW + OccW)'(cnt);
    return wide[OccW-1:0];
  endfunction

endpackage

// ----- rtl/bfsm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bfsm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsm_ctrl
// Ring pointers, fill count, overflow flag and sync mark bits; decides each
// operation and issues the byte store access.
// ----------------------------------------------------------------------------
module bfsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bfsm_pkg::in_item_t  item_i,
  output bfsm_pkg::beat_info_t info_o,
  output bfsm_pkg::ram_req_t  ram_req_o
);
  import bfsm_pkg::*;

  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [Depth-1:0] marks_q, marks_d;
  logic             full, empty;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    marks_d = marks_q;
    info_o  = '0;
    ram_req_o       = '0;
    ram_req_o.waddr = tail_q;
    ram_req_o.wdata = item_i.data_in;
    ram_req_o.raddr = head_q;
    if (accept_i) begin
      unique case (item_i.operation)
        OP_PUSH: begin
          if (!full) begin
            ram_req_o.we    = 1'b1;
            tail_d          = ring_next(tail_q);
            count_d         = count_q + CntW'(1);
            info_o.accepted = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        OP_POP: begin
          if (!empty) begin
            ram_req_o.re     = 1'b1;
            info_o.sync_mark = marks_q[head_q];
            marks_d[head_q]  = 1'b0;
            head_d           = ring_next(head_q);
            count_d          = count_q - CntW'(1);
            info_o.accepted  = 1'b1;
            info_o.pop_ok    = 1'b1;
          end
        end
        OP_MARK: begin
          marks_d[ring_prev(tail_q)] = 1'b1;
          info_o.accepted            = 1'b1;
        end
        OP_CLEAR: begin
          head_d          = '0;
          tail_d          = '0;
          count_d         = '0;
          ovf_d           = 1'b0;
          marks_d         = '0;
          info_o.accepted = 1'b1;
        end
        default: begin
          info_o.accepted = 1'b0;
        end
      endcase
    end
    info_o.occupancy    = occ_of(count_d);
    info_o.error_status = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      marks_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      marks_q <= marks_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count above depth");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (head_q == tail_q))
    else $error("pointers disagree with fill count");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.operation == OP_CLEAR) |=> (empty && !ovf_q && marks_q == '0))
    else $error("clear left state behind");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.operation == OP_POP && !empty)
      |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not drop fill count");

  a_ovf_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !(accept_i && item_i.operation == OP_CLEAR)) |=> ovf_q)
    else $error("overflow flag lost without clear");

endmodule

// ----- rtl/byte_fifo_with_sync_marks.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_fifo_with_sync_marks
// Byte ring FIFO with a sync mark per slot: push, pop, mark and clear.
// Path: an accepted operation's byte store read and info are registered in the
// first stage; the result beat is then presented from the output register.
// Throughput: one operation per cycle; the input stalls only while both stages
// hold beats and out_stall_i holds the output beat.
// Reset: asynchronous, active low; empties the FIFO, clears all marks and
// the overflow flag. Byte store contents are not reset.
// ----------------------------------------------------------------------------
module byte_fifo_with_sync_marks (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfsm_pkg::out_item_t out_data_o
);
  import bfsm_pkg::*;

  logic             accept;
  logic             out_free;
  logic             s1_adv;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  beat_info_t       info;
  beat_info_t       s1_info_q;
  ram_req_t         ram_req;
  logic [ByteW-1:0] rdata;
  out_item_t        out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  bfsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_data_i),
    .info_o    (info),
    .ram_req_o (ram_req)
  );

  bfsm_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
    if (s1_adv) begin
      out_q.accepted     <= s1_info_q.accepted;
      out_q.data_out     <= s1_info_q.pop_ok ? rdata : '0;
      out_q.sync_mark    <= s1_info_q.sync_mark;
      out_q.occupancy    <= s1_info_q.occupancy;
      out_q.error_status <= s1_info_q.error_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
